@@ hw/rtl/rounded_window_pixel_blend_defines.svh @@
// assertion macros used by the checker file
`ifndef ROUNDED_WINDOW_PIXEL_BLEND_DEFINES_SVH
`define ROUNDED_WINDOW_PIXEL_BLEND_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RWPB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rwpb check failed");

// next-cycle implication, disabled while reset is asserted
`define RWPB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rwpb check failed");

`endif

@@ hw/rtl/rwpb_pkg.sv @@
package rwpb_pkg;

    localparam int unsigned CFG_W       = 13;
    localparam int unsigned COORD_W     = 12;
    localparam int unsigned COLOR_W     = 32;
    localparam int unsigned RADIUS_W    = 8;
    localparam int unsigned OFS_W       = 16;
    localparam int unsigned ALPHA_SHIFT = 24;

    localparam logic [23:0] RB_MASK   = 24'hFF00FF;
    localparam logic [23:0] G_MASK    = 24'h00FF00;
    localparam logic [8:0]  ALPHA_ONE = 9'd256;

    typedef enum logic [2:0] {
        CFG_WINDOW_LEFT   = 3'd0,
        CFG_WINDOW_TOP    = 3'd1,
        CFG_WINDOW_WIDE   = 3'd2,
        CFG_WINDOW_TALL   = 3'd3,
        CFG_CORNER_RADIUS = 3'd4,
        CFG_ROUND_ENABLE  = 3'd5,
        CFG_BLEND_ENABLE  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] left;
        logic signed [CFG_W-1:0] top;
        logic [CFG_W-1:0]        wide;
        logic [CFG_W-1:0]        tall;
        logic [RADIUS_W-1:0]     radius;
        logic                    round_en;
        logic                    blend_en;
    } rwpb_cfg_t;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } rwpb_adv_t;

endpackage

@@ hw/rtl/rounded_window_pixel_blend.sv @@
// Per-pixel window composition with rounded-corner masking and alpha-over blend.
// Input stream s_*: one word per pixel carrying screen position, window ARGB
// color and the framebuffer ARGB color beneath it. Output stream m_*: one word
// per input word, tuser = 1 means write tdata to the framebuffer, tuser = 0
// means the pixel falls in a rounded-off corner and is left as is (tdata = 0).
// Configuration is a write-only register port (cfg_we/cfg_index/cfg_data); the
// user must write it only while no pixel is in flight; the block does not enforce it.
// Pipeline: three register stages (offsets and under-alpha scaling, squares
// and channel products, corner compare and final color).
// Throughput: one word per clock; each stage loads a new word unless stalled.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register
// defaults: origin 0, size 1x1, radius 0, masking and blending off.
// When m_tready is low the output word holds; stages upstream keep filling
// empty slots, so s_tready drops only once all three stages hold a word.
module rounded_window_pixel_blend (
    input  logic        aclk,
    input  logic        aresetn,
    // config register port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // input pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,    // pixel_x, pixel_y, window_color, under_color
    // output pixel stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // out_color
    output logic        m_tuser     // write_pixel
);
    import rwpb_pkg::*;

    rwpb_cfg_t cfg_reg;
    rwpb_adv_t adv;

    logic v1_reg, v2_reg, vout_reg;

    logic               masked;
    logic [COLOR_W-1:0] color;

    logic [COLOR_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left     <= '0;
            cfg_reg.top      <= '0;
            cfg_reg.wide     <= 13'd1;
            cfg_reg.tall     <= 13'd1;
            cfg_reg.radius   <= '0;
            cfg_reg.round_en <= 1'b0;
            cfg_reg.blend_en <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WINDOW_LEFT:   cfg_reg.left     <= cfg_data;
                CFG_WINDOW_TOP:    cfg_reg.top      <= cfg_data;
                CFG_WINDOW_WIDE:   cfg_reg.wide     <= cfg_data;
                CFG_WINDOW_TALL:   cfg_reg.tall     <= cfg_data;
                CFG_CORNER_RADIUS: cfg_reg.radius   <= cfg_data[RADIUS_W-1:0];
                CFG_ROUND_ENABLE:  cfg_reg.round_en <= cfg_data[0];
                CFG_BLEND_ENABLE:  cfg_reg.blend_en <= cfg_data[0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // a stage loads when it is empty or its word moves on this cycle
    assign adv.s3   = !vout_reg || m_tready;
    assign adv.s2   = !v2_reg || adv.s3;
    assign adv.s1   = !v1_reg || adv.s2;
    assign s_tready = adv.s1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end else begin
            if (adv.s1) begin
                v1_reg <= s_tvalid;
            end
            if (adv.s2) begin
                v2_reg <= v1_reg;
            end
            if (adv.s3) begin
                vout_reg <= v2_reg;
            end
        end
    end

    // corner geometry path
    rwpb_mask u_mask (
        .aclk    (aclk),
        .cfg     (cfg_reg),
        .adv     (adv),
        .pixel_x (s_tdata[11:0]),
        .pixel_y (s_tdata[23:12]),
        .masked  (masked)
    );

    // color path
    rwpb_blend u_blend (
        .aclk         (aclk),
        .adv          (adv),
        .blend_en     (cfg_reg.blend_en),
        .window_color (s_tdata[55:24]),
        .under_color  (s_tdata[87:56]),
        .color        (color)
    );

    // output register, rounded-off pixels carry a zero color
    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            m_tdata_reg <= masked ? '0 : color;
            m_tuser_reg <= !masked;
        end
    end

    assign m_tvalid = vout_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ hw/rtl/rwpb_mask.sv @@
module rwpb_mask (
    input  logic                                 aclk,
    input  rwpb_pkg::rwpb_cfg_t                  cfg,
    input  rwpb_pkg::rwpb_adv_t                  adv,
    input  logic [rwpb_pkg::COORD_W-1:0]         pixel_x,
    input  logic [rwpb_pkg::COORD_W-1:0]         pixel_y,
    output logic                                 masked
);
    import rwpb_pkg::*;

    logic signed [OFS_W-1:0] rad_s, org_x, org_y, pos_x, pos_y;
    logic signed [OFS_W-1:0] ofs_l, ofs_r, ofs_t, ofs_b;

    logic                in_l_reg, in_r_reg, in_t_reg, in_b_reg;
    logic [RADIUS_W-1:0] mag_l_reg, mag_r_reg, mag_t_reg, mag_b_reg;

    logic                   in_l2_reg, in_r2_reg, in_t2_reg, in_b2_reg;
    logic [2*RADIUS_W-1:0]  sq_l_reg, sq_r_reg, sq_t_reg, sq_b_reg, r2_reg;

    logic hit_tl, hit_tr, hit_bl, hit_br;

    // distance to the corner center, counted 1..radius inside a corner square
    assign rad_s = {{(OFS_W-RADIUS_W){1'b0}}, cfg.radius};
    assign org_x = {{(OFS_W-CFG_W){cfg.left[CFG_W-1]}}, cfg.left};
    assign org_y = {{(OFS_W-CFG_W){cfg.top[CFG_W-1]}}, cfg.top};
    assign pos_x = {{(OFS_W-COORD_W){1'b0}}, pixel_x};
    assign pos_y = {{(OFS_W-COORD_W){1'b0}}, pixel_y};

    assign ofs_l = org_x + rad_s - pos_x;
    assign ofs_t = org_y + rad_s - pos_y;
    assign ofs_r = pos_x - org_x - {{(OFS_W-CFG_W){1'b0}}, cfg.wide} + rad_s + 16'sd1;
    assign ofs_b = pos_y - org_y - {{(OFS_W-CFG_W){1'b0}}, cfg.tall} + rad_s + 16'sd1;

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            in_l_reg  <= (ofs_l > 16'sd0) && (ofs_l <= rad_s);
            in_r_reg  <= (ofs_r > 16'sd0) && (ofs_r <= rad_s);
            in_t_reg  <= (ofs_t > 16'sd0) && (ofs_t <= rad_s);
            in_b_reg  <= (ofs_b > 16'sd0) && (ofs_b <= rad_s);
            mag_l_reg <= ofs_l[RADIUS_W-1:0];
            mag_r_reg <= ofs_r[RADIUS_W-1:0];
            mag_t_reg <= ofs_t[RADIUS_W-1:0];
            mag_b_reg <= ofs_b[RADIUS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            in_l2_reg <= in_l_reg;
            in_r2_reg <= in_r_reg;
            in_t2_reg <= in_t_reg;
            in_b2_reg <= in_b_reg;
            sq_l_reg  <= mag_l_reg * mag_l_reg;
            sq_r_reg  <= mag_r_reg * mag_r_reg;
            sq_t_reg  <= mag_t_reg * mag_t_reg;
            sq_b_reg  <= mag_b_reg * mag_b_reg;
            r2_reg    <= cfg.radius * cfg.radius;
        end
    end

    assign hit_tl = in_l2_reg && in_t2_reg &&
                    (({1'b0, sq_l_reg} + {1'b0, sq_t_reg}) >= {1'b0, r2_reg});
    assign hit_tr = in_r2_reg && in_t2_reg &&
                    (({1'b0, sq_r_reg} + {1'b0, sq_t_reg}) >= {1'b0, r2_reg});
    assign hit_bl = in_l2_reg && in_b2_reg &&
                    (({1'b0, sq_l_reg} + {1'b0, sq_b_reg}) >= {1'b0, r2_reg});
    assign hit_br = in_r2_reg && in_b2_reg &&
                    (({1'b0, sq_r_reg} + {1'b0, sq_b_reg}) >= {1'b0, r2_reg});

    assign masked = cfg.round_en && (hit_tl || hit_tr || hit_bl || hit_br);

endmodule

@@ hw/rtl/rwpb_blend.sv @@
module rwpb_blend (
    input  logic                          aclk,
    input  rwpb_pkg::rwpb_adv_t           adv,
    input  logic                          blend_en,
    input  logic [rwpb_pkg::COLOR_W-1:0]  window_color,
    input  logic [rwpb_pkg::COLOR_W-1:0]  under_color,
    output logic [rwpb_pkg::COLOR_W-1:0]  color
);
    import rwpb_pkg::*;

    logic [7:0]  aa_in, ua_in;
    logic [16:0] ab_prod;

    logic [7:0]          aa_reg, ab_reg;
    logic [COLOR_W-1:0]  wc_reg, uc_reg;

    logic [31:0] rb1_prod, rb2_prod, g1_prod, g2_prod;
    logic [7:0]          a2_reg;
    logic [23:0]         rb1_reg, rb2_reg, g1_reg, g2_reg;
    logic [COLOR_W-1:0]  wc2_reg;

    logic [23:0] mixed;

    // under alpha scaled by what the window leaves uncovered
    assign aa_in   = window_color[ALPHA_SHIFT +: 8];
    assign ua_in   = under_color[ALPHA_SHIFT +: 8];
    assign ab_prod = {9'b0, ua_in} * {8'b0, ALPHA_ONE - {1'b0, aa_in}};

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            aa_reg <= aa_in;
            ab_reg <= ab_prod[15:8];
            wc_reg <= window_color;
            uc_reg <= under_color;
        end
    end

    assign rb1_prod = {24'b0, aa_reg} * {8'b0, wc_reg[23:0] & RB_MASK};
    assign rb2_prod = {24'b0, ab_reg} * {8'b0, uc_reg[23:0] & RB_MASK};
    assign g1_prod  = {24'b0, aa_reg} * {8'b0, wc_reg[23:0] & G_MASK};
    assign g2_prod  = {24'b0, ab_reg} * {8'b0, uc_reg[23:0] & G_MASK};

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            a2_reg  <= aa_reg + ab_reg;
            rb1_reg <= rb1_prod[31:8];
            rb2_reg <= rb2_prod[31:8];
            g1_reg  <= g1_prod[31:8];
            g2_reg  <= g2_prod[31:8];
            wc2_reg <= wc_reg;
        end
    end

    // partial terms are or-ed, not added
    assign mixed = ((rb1_reg | rb2_reg) & RB_MASK) | ((g1_reg | g2_reg) & G_MASK);
    assign color = blend_en ? {a2_reg, mixed} : wc2_reg;

endmodule

@@ hw/rtl/rwpb_checker.sv @@
`include "rounded_window_pixel_blend_defines.svh"

module rwpb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // a rounded-off pixel never carries color
    `RWPB_ASSERT_IMP(a_masked_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == 32'd0)

    // with no word waiting at the output the whole pipeline can take input
    `RWPB_ASSERT_IMP(a_ready_when_out_empty, aclk, aresetn, !m_tvalid, s_tready)

    // the first cycle out of reset shows an empty output
    `RWPB_ASSERT_IMP(a_empty_after_reset, aclk, aresetn, $rose(aresetn), !m_tvalid)

    // a stalled output word holds
    `RWPB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind rounded_window_pixel_blend rwpb_checker u_rwpb_checker (.*);

@@ test/tb_rounded_window_pixel_blend.sv @@
`timescale 1ns / 1ps

module tb_rounded_window_pixel_blend;
    import rwpb_pkg::*;

    // pipeline depth of the block, three register stages
    localparam int PIPE_LATENCY = 3;
    // random part: one window setting per phase, then a run of pixels
    localparam int RANDOM_PHASES = 10;
    localparam int PIXELS_PER_PHASE = 70;
    // hard stop, far above the slowest legal run
    localparam int RUN_LIMIT_NS = 3_000_000;
    // register index that the block does not decode
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    // composed pixel as it leaves the block
    typedef struct packed {
        logic        write_pixel;
        logic [31:0] out_color;
    } composed_t;

    typedef enum bit {
        ROW_REG,
        ROW_PIXEL
    } row_kind_t;

    // one line of the directed table: a register write or a pixel word
    typedef struct {
        row_kind_t   kind;
        logic [2:0]  reg_index;
        logic [12:0] reg_value;
        logic [11:0] px;
        logic [11:0] py;
        logic [31:0] window_color;
        logic [31:0] under_color;
        bit          exp_given;     // expectation typed in below, else predicted
        logic        want_write;
        logic [31:0] want_color;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;      // pixel_x, pixel_y, window_color, under_color
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // out_color
    logic        m_tuser;           // write_pixel

    // shadow of the block's registers, kept in step with every write
    rwpb_cfg_t shadow_cfg = '{left: '0, top: '0, wide: 13'd1, tall: 13'd1,
                              radius: '0, round_en: 1'b0, blend_en: 1'b0};

    composed_t pending_results[$];
    int        error_count = 0;
    int        burst_left = 0;

    // ready pattern of the receiver, reloaded whenever ready_phase wraps to zero
    logic [31:0] ready_bits = '1;
    logic [4:0]  ready_phase = '0;

    rounded_window_pixel_blend u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // directed table: reset state, copy and blend extremes, the four corners,
    // radius zero, unmapped index, tiny and huge windows
    directed_row_t directed_rows[$] = '{
        // after reset: plain copy of the window pixel
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd0, 12'd0,
          32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b1, 32'hFFFFFFFF},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'hFFF, 12'hFFF,
          32'h00000000, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h00000000},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'h555, 12'hAAA,
          32'h12345678, 32'h9ABCDEF0, 1'b1, 1'b1, 32'h12345678},
        // blending on: transparent over transparent, then the alpha extremes
        '{ROW_REG, CFG_BLEND_ENABLE, 13'd1, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd0, 12'd0,
          32'h00FFFFFF, 32'h00000000, 1'b1, 1'b1, 32'h00000000},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd1, 12'd1,
          32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd2, 12'd2,
          32'h00FFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd3, 12'd3,
          32'h80808080, 32'hFF204060, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd4, 12'd4,
          32'hFF123456, 32'h00ABCDEF, 1'b0, 1'b0, 32'h0},
        // window at (10,20), 100 x 50, radius 8, mask on
        '{ROW_REG, CFG_BLEND_ENABLE, 13'd0, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_LEFT, 13'd10, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_TOP, 13'd20, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_WIDE, 13'd100, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_TALL, 13'd50, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_CORNER_RADIUS, 13'd8, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_ROUND_ENABLE, 13'd1, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        // outermost pixel of each corner is rounded off
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd10, 12'd20,
          32'hDEADBEEF, 32'h01234567, 1'b1, 1'b0, 32'h00000000},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd109, 12'd20,
          32'hDEADBEEF, 32'h01234567, 1'b1, 1'b0, 32'h00000000},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd10, 12'd69,
          32'hDEADBEEF, 32'h01234567, 1'b1, 1'b0, 32'h00000000},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd109, 12'd69,
          32'hDEADBEEF, 32'h01234567, 1'b1, 1'b0, 32'h00000000},
        // near the arc on both sides, outside the window, next to the square
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd17, 12'd27,
          32'hCAFEF00D, 32'h76543210, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd13, 12'd22,
          32'hCAFEF00D, 32'h76543210, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd12, 12'd22,
          32'hCAFEF00D, 32'h76543210, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd0, 12'd0,
          32'hCAFEF00D, 32'h76543210, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd18, 12'd20,
          32'hCAFEF00D, 32'h76543210, 1'b0, 1'b0, 32'h0},
        // mask wins over blending
        '{ROW_REG, CFG_BLEND_ENABLE, 13'd1, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd10, 12'd20,
          32'h80FF8040, 32'hFF102030, 1'b1, 1'b0, 32'h00000000},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd60, 12'd40,
          32'h80FF8040, 32'hFF102030, 1'b0, 1'b0, 32'h0},
        // radius zero masks nothing
        '{ROW_REG, CFG_CORNER_RADIUS, 13'd0, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd10, 12'd20,
          32'h40FF8040, 32'hC0102030, 1'b0, 1'b0, 32'h0},
        // write to an unmapped index changes nothing
        '{ROW_REG, REG_UNMAPPED, 13'h1FFF, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd109, 12'd69,
          32'h40FF8040, 32'hC0102030, 1'b0, 1'b0, 32'h0},
        // 1 x 1 window with the largest radius
        '{ROW_REG, CFG_CORNER_RADIUS, 13'd255, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_WIDE, 13'd1, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_TALL, 13'd1, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_LEFT, 13'd0, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_TOP, 13'd0, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd0, 12'd0,
          32'hFF00FF00, 32'h00FF00FF, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd200, 12'd200,
          32'hFF00FF00, 32'h00FF00FF, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'd0, 12'd254,
          32'hFF00FF00, 32'h00FF00FF, 1'b0, 1'b0, 32'h0},
        // most negative left, largest top, width 4096, zero height
        '{ROW_REG, CFG_WINDOW_LEFT, 13'h1000, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_TOP, 13'h0FFF, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_WIDE, 13'h1000, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_REG, CFG_WINDOW_TALL, 13'd0, 12'd0, 12'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_PIXEL, REG_UNMAPPED, 13'd0, 12'hFFF, 12'hFFF,
          32'h7FFFFFFF, 32'h80FFFFFF, 1'b0, 1'b0, 32'h0}
    };

    // alpha-over in integer form, partial channel terms ORed
    function automatic logic [31:0] alpha_over(logic [31:0] wc, logic [31:0] uc);
        longint unsigned aa, ab, a, rb1, rb2, g1, g2;
        aa  = wc[31:24];
        ab  = (longint'(uc[31:24]) * (256 - aa)) >> 8;
        a   = (aa + ab) & 64'hFF;
        rb1 = (aa * (wc & {8'h00, RB_MASK})) >> 8;
        rb2 = (ab * (uc & {8'h00, RB_MASK})) >> 8;
        g1  = (aa * (wc & {8'h00, G_MASK})) >> 8;
        g2  = (ab * (uc & {8'h00, G_MASK})) >> 8;
        return (32'(a) << ALPHA_SHIFT) | 32'((rb1 | rb2) & {40'h0, RB_MASK})
             | 32'((g1 | g2) & {40'h0, G_MASK});
    endfunction

    // true when the position falls outside the arc of one of the corners
    function automatic bit in_rounded_corner(logic [11:0] px_in, logic [11:0] py_in);
        longint l, t, w, h, r, px, py, ax, ay, cx, cy, dx, dy;
        bit right, bottom;
        if (!shadow_cfg.round_en)
            return 1'b0;
        l  = longint'($signed(shadow_cfg.left));
        t  = longint'($signed(shadow_cfg.top));
        w  = longint'(shadow_cfg.wide);
        h  = longint'(shadow_cfg.tall);
        r  = longint'(shadow_cfg.radius);
        px = longint'(px_in);
        py = longint'(py_in);
        for (int c = 0; c < 4; c++) begin
            right  = c[0];
            bottom = c[1];
            ax = right ? l + w - r : l;
            ay = bottom ? t + h - r : t;
            cx = right ? l + (w - 1) - r : l + r;
            cy = bottom ? t + (h - 1) - r : t + r;
            if (px < ax || px >= ax + r || py < ay || py >= ay + r)
                continue;
            dx = px - cx;
            dy = py - cy;
            // only the quadrant that faces this corner counts
            if ((dx > 0) != right || (dy > 0) != bottom)
                continue;
            if (dx * dx + dy * dy >= r * r)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic composed_t compose_pixel(logic [11:0] px, logic [11:0] py,
                                                logic [31:0] wc, logic [31:0] uc);
        if (in_rounded_corner(px, py))
            return '{write_pixel: 1'b0, out_color: 32'h0};
        return '{write_pixel: 1'b1, out_color: shadow_cfg.blend_en ? alpha_over(wc, uc) : wc};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // register write on the falling edge, mirrored into the shadow copy
    task automatic set_register(logic [2:0] index, logic [12:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (index)
            CFG_WINDOW_LEFT:   shadow_cfg.left     = value;
            CFG_WINDOW_TOP:    shadow_cfg.top      = value;
            CFG_WINDOW_WIDE:   shadow_cfg.wide     = value;
            CFG_WINDOW_TALL:   shadow_cfg.tall     = value;
            CFG_CORNER_RADIUS: shadow_cfg.radius   = value[7:0];
            CFG_ROUND_ENABLE:  shadow_cfg.round_en = value[0];
            CFG_BLEND_ENABLE:  shadow_cfg.blend_en = value[0];
            default: ;
        endcase
    endtask

    // stop sending, wait for every result, then let the pipe run empty
    task automatic settle_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    // one word on the input stream, sent in bursts with random gaps between
    task automatic send_pixel(logic [11:0] px, logic [11:0] py, logic [31:0] wc,
                              logic [31:0] uc, bit exp_given, composed_t given);
        int        gap;
        composed_t next_result;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {uc, wc, py, px};
        do
            @(posedge aclk);
        while (!s_tready);
        next_result = exp_given ? given : compose_pixel(px, py, wc, uc);
        pending_results = {pending_results, next_result};
    endtask

    // receiver: a fresh ready pattern whenever ready_phase wraps, from never
    // stalling to long stalls
    always @(negedge aclk) begin
        if (ready_phase == 0) begin
            case ($urandom_range(0, 5))
                0, 1: ready_bits = '1;
                2:    ready_bits = $urandom;
                3:    ready_bits = $urandom | $urandom;
                4:    ready_bits = 32'hEEEE_EEEE;
                default: ready_bits = 32'hFFFF_0000;
            endcase
        end
        m_tready <= ready_bits[ready_phase];
        ready_phase = ready_phase + 1'b1;
    end

    // result checker: every accepted word against the oldest expectation
    always @(posedge aclk) begin
        composed_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("word with nothing pending", m_tdata, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.write_pixel)
                    report_mismatch("write_pixel", 32'(m_tuser), 32'(want.write_pixel));
                if (m_tdata !== want.out_color)
                    report_mismatch("out_color", m_tdata, want.out_color);
            end
        end
    end

    initial begin
        int          new_left, new_top, new_wide, new_tall, new_radius;
        bit          new_round, new_blend;
        int          corner, pos_x, pos_y;
        logic [11:0] px, py;
        logic [31:0] wc, uc;

        // reset once, at the start of the run
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                settle_pipeline();
                set_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end else begin
                send_pixel(directed_rows[i].px, directed_rows[i].py,
                           directed_rows[i].window_color, directed_rows[i].under_color,
                           directed_rows[i].exp_given,
                           composed_t'{directed_rows[i].want_write,
                                       directed_rows[i].want_color});
            end
        end

        // random phases, the first three at the register extremes
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_pipeline();
            case (phase)
                0: begin
                    // full screen window, largest corners
                    new_left = 0;     new_top = 0;     new_wide = 4096; new_tall = 4096;
                    new_radius = 255; new_round = 1'b1; new_blend = 1'b1;
                end
                1: begin
                    new_left = -4096; new_top = -4096; new_wide = 1;    new_tall = 1;
                    new_radius = 0;   new_round = 1'b1; new_blend = 1'b0;
                end
                2: begin
                    // top left corner lands on the last screen pixel
                    new_left = 4095;  new_top = 4095;  new_wide = 4096; new_tall = 4096;
                    new_radius = 255; new_round = 1'b1; new_blend = 1'b0;
                end
                default: begin
                    new_left = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                                           : int'($urandom_range(0, 3800)) - 200;
                    new_top  = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                                           : int'($urandom_range(0, 3800)) - 200;
                    case ($urandom_range(0, 6))
                        0:       new_wide = 0;
                        1:       new_wide = 4096;
                        2:       new_wide = $urandom_range(1, 4096);
                        default: new_wide = $urandom_range(1, 400);
                    endcase
                    case ($urandom_range(0, 6))
                        0:       new_tall = 0;
                        1:       new_tall = 4096;
                        2:       new_tall = $urandom_range(1, 4096);
                        default: new_tall = $urandom_range(1, 400);
                    endcase
                    case ($urandom_range(0, 6))
                        0:       new_radius = 0;
                        1:       new_radius = 255;
                        2:       new_radius = 1;
                        3:       new_radius = $urandom_range(0, 255);
                        default: new_radius = $urandom_range(2, 40);
                    endcase
                    new_round = ($urandom_range(0, 3) != 0);
                    new_blend = 1'($urandom_range(0, 1));
                end
            endcase
            // narrow registers get junk in the unused data bits
            set_register(CFG_WINDOW_LEFT, 13'(new_left));
            set_register(CFG_WINDOW_TOP, 13'(new_top));
            set_register(CFG_WINDOW_WIDE, 13'(new_wide));
            set_register(CFG_WINDOW_TALL, 13'(new_tall));
            set_register(CFG_CORNER_RADIUS, {5'($urandom), 8'(new_radius)});
            set_register(CFG_ROUND_ENABLE, {12'($urandom), new_round});
            set_register(CFG_BLEND_ENABLE, {12'($urandom), new_blend});
            if ($urandom_range(0, 3) == 0)
                set_register(REG_UNMAPPED, 13'($urandom));

            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                if (new_round && $urandom_range(0, 9) < 7) begin
                    // inside a corner square or one pixel past its edge
                    corner = $urandom_range(0, 3);
                    pos_x = corner[0] ? new_left + new_wide - new_radius : new_left;
                    pos_y = corner[1] ? new_top + new_tall - new_radius : new_top;
                    pos_x = pos_x + int'($urandom_range(0, new_radius + 1)) - 1;
                    pos_y = pos_y + int'($urandom_range(0, new_radius + 1)) - 1;
                    px = 12'(pos_x);
                    py = 12'(pos_y);
                end else if ($urandom_range(0, 1) == 1) begin
                    // in or just around the window
                    px = 12'(new_left + int'($urandom_range(0, new_wide + 1)) - 1);
                    py = 12'(new_top + int'($urandom_range(0, new_tall + 1)) - 1);
                end else begin
                    px = 12'($urandom);
                    py = 12'($urandom);
                end
                wc = $urandom;
                uc = $urandom;
                // opaque and transparent alphas show up often
                case ($urandom_range(0, 3))
                    0: wc[31:24] = 8'h00;
                    1: wc[31:24] = 8'hFF;
                    default: ;
                endcase
                case ($urandom_range(0, 3))
                    0: uc[31:24] = 8'h00;
                    1: uc[31:24] = 8'hFF;
                    default: ;
                endcase
                send_pixel(px, py, wc, uc, 1'b0, '0);
            end
        end

        settle_pipeline();
        if (error_count == 0)
            $display("tb_rounded_window_pixel_blend: done, clean");
        else
            $display("tb_rounded_window_pixel_blend: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_rounded_window_pixel_blend: done, errors");
        $finish;
    end

endmodule

@@ rounded_window_pixel_blend.f @@
+incdir+hw/rtl
hw/rtl/rwpb_pkg.sv
hw/rtl/rwpb_mask.sv
hw/rtl/rwpb_blend.sv
hw/rtl/rounded_window_pixel_blend.sv
hw/rtl/rwpb_checker.sv
test/tb_rounded_window_pixel_blend.sv
